// ----- design/round_robin_task_scheduler_macros.svh -----
// Assertion macros for the round-robin task scheduler.
// Depends on nothing; included by the files that carry assertions.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define RRTS_ASSERT_IMP(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |-> (cons)) \
    else $error("scheduler assertion failed");
// next-cycle implication, disabled during reset
`define RRTS_ASSERT_NXT(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |=> (cons)) \
    else $error("scheduler assertion failed");
`else
`define RRTS_ASSERT_IMP(lbl, clk, rst_n, ant, cons)
`define RRTS_ASSERT_NXT(lbl, clk, rst_n, ant, cons)
`endif

`endif

// ----- design/rrts_pkg.sv -----
// Shared types, codes and microcode ROM of the round-robin task scheduler.
// Depends on nothing.
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int TIDX_W    = 3;
  localparam int FUNC_W    = 3;
  localparam int TICK_W    = 32;
  localparam int CFG_W     = 4;

  // task states
  localparam logic [1:0] ST_READY    = 2'd0;
  localparam logic [1:0] ST_RUNNING  = 2'd1;
  localparam logic [1:0] ST_SLEEPING = 2'd2;
  localparam logic [1:0] ST_BLOCKED  = 2'd3;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_TICK     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SCHEDULE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SLEEP    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_BLOCK    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_UNBLOCK  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_QUERY    = 3'd5;

  // datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_TICK_INC = 4'd1;
  localparam logic [OP_W-1:0] OP_TICK_CHK = 4'd2;
  localparam logic [OP_W-1:0] OP_DEMOTE   = 4'd3;
  localparam logic [OP_W-1:0] OP_MODN     = 4'd4;
  localparam logic [OP_W-1:0] OP_SRCH     = 4'd5;
  localparam logic [OP_W-1:0] OP_COMMIT   = 4'd6;
  localparam logic [OP_W-1:0] OP_SLEEP    = 4'd7;
  localparam logic [OP_W-1:0] OP_BLOCK    = 4'd8;
  localparam logic [OP_W-1:0] OP_UNBLK    = 4'd9;
  localparam logic [OP_W-1:0] OP_QUERY    = 4'd10;
  localparam logic [OP_W-1:0] OP_OUT      = 4'd11;

  // microcode step addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_TICK_INC = 4'd1;
  localparam logic [PC_W-1:0] PC_TICK_CHK = 4'd2;
  localparam logic [PC_W-1:0] PC_DEMOTE   = 4'd3;
  localparam logic [PC_W-1:0] PC_MODN     = 4'd4;
  localparam logic [PC_W-1:0] PC_SRCH     = 4'd5;
  localparam logic [PC_W-1:0] PC_COMMIT   = 4'd6;
  localparam logic [PC_W-1:0] PC_SLEEP    = 4'd7;
  localparam logic [PC_W-1:0] PC_BLOCK    = 4'd8;
  localparam logic [PC_W-1:0] PC_UNBLK    = 4'd9;
  localparam logic [PC_W-1:0] PC_OUT      = 4'd10;
  localparam logic [PC_W-1:0] PC_QUERY    = 4'd11;

  // one control word
  typedef struct packed {
    logic            disp;  // dispatch on an incoming item
    logic            rpt;   // hold this step while the datapath reports busy
    logic [OP_W-1:0] op;
    logic [PC_W-1:0] nxt;
  } ctl_t;

  typedef struct packed {
    logic busy;
  } stat_t;

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    case (pc)
      PC_IDLE:     w = '{disp: 1'b1, rpt: 1'b0, op: OP_NONE,     nxt: PC_IDLE};
      PC_TICK_INC: w = '{disp: 1'b0, rpt: 1'b0, op: OP_TICK_INC, nxt: PC_TICK_CHK};
      PC_TICK_CHK: w = '{disp: 1'b0, rpt: 1'b1, op: OP_TICK_CHK, nxt: PC_OUT};
      PC_DEMOTE:   w = '{disp: 1'b0, rpt: 1'b0, op: OP_DEMOTE,   nxt: PC_MODN};
      PC_MODN:     w = '{disp: 1'b0, rpt: 1'b1, op: OP_MODN,     nxt: PC_SRCH};
      PC_SRCH:     w = '{disp: 1'b0, rpt: 1'b1, op: OP_SRCH,     nxt: PC_COMMIT};
      PC_COMMIT:   w = '{disp: 1'b0, rpt: 1'b0, op: OP_COMMIT,   nxt: PC_OUT};
      PC_SLEEP:    w = '{disp: 1'b0, rpt: 1'b0, op: OP_SLEEP,    nxt: PC_OUT};
      PC_BLOCK:    w = '{disp: 1'b0, rpt: 1'b0, op: OP_BLOCK,    nxt: PC_OUT};
      PC_UNBLK:    w = '{disp: 1'b0, rpt: 1'b0, op: OP_UNBLK,    nxt: PC_OUT};
      PC_OUT:      w = '{disp: 1'b0, rpt: 1'b1, op: OP_OUT,      nxt: PC_IDLE};
      PC_QUERY:    w = '{disp: 1'b0, rpt: 1'b0, op: OP_QUERY,    nxt: PC_OUT};
      default:     w = '{disp: 1'b0, rpt: 1'b0, op: OP_NONE,     nxt: PC_IDLE};
    endcase
    return w;
  endfunction

  // entry step for each operation; unused codes go straight to the result
  function automatic logic [PC_W-1:0] entry(input logic [FUNC_W-1:0] fn);
    logic [PC_W-1:0] pc;
    case (fn)
      FN_TICK:     pc = PC_TICK_INC;
      FN_SCHEDULE: pc = PC_DEMOTE;
      FN_SLEEP:    pc = PC_SLEEP;
      FN_BLOCK:    pc = PC_BLOCK;
      FN_UNBLOCK:  pc = PC_UNBLK;
      FN_QUERY:    pc = PC_QUERY;
      default:     pc = PC_OUT;
    endcase
    return pc;
  endfunction

endpackage

// ----- design/rrts_seq.sv -----
// Microcode sequencer: step counter, control ROM lookup, dispatch and repeat.
// Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic [rrts_pkg::FUNC_W-1:0] in_func,
  input  rrts_pkg::stat_t            stat,
  output rrts_pkg::ctl_t             ctl,
  output logic                       in_tready
);

  logic [rrts_pkg::PC_W-1:0] pc_r, pc_nxt;

  assign ctl       = rrts_pkg::ucode(pc_r);
  assign in_tready = ctl.disp;

  always_comb begin
    if (ctl.disp) begin
      pc_nxt = in_tvalid ? rrts_pkg::entry(in_func) : pc_r;
    end else if (ctl.rpt && stat.busy) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = ctl.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= rrts_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- design/rrts_datapath.sv -----
// Scheduler datapath: task state table, wake times, tick counter, walk
// index and result register. Driven one control word per cycle.
// Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rrts_pkg::ctl_t               ctl,
  output rrts_pkg::stat_t              stat,
  input  logic [rrts_pkg::CFG_W-1:0]   cfg_tasks,
  input  logic                         in_tvalid,
  input  logic [rrts_pkg::TICK_W-1:0]  in_sleep_ticks,
  input  logic [rrts_pkg::TIDX_W-1:0]  in_task_sel,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [rrts_pkg::TIDX_W-1:0]  out_active_task,
  output logic [rrts_pkg::TICK_W-1:0]  out_now_ticks,
  output logic [1:0]                   out_queried_state,
  output logic                         out_index_valid,
  output logic                         out_switch_request
);

  localparam int IW = rrts_pkg::IDX_W;
  localparam int CW = rrts_pkg::CNT_W;
  localparam int TW = rrts_pkg::TICK_W;

  logic [1:0]  state_r [rrts_pkg::MAX_TASKS];
  logic [TW-1:0] wake_r [rrts_pkg::MAX_TASKS];
  logic [IW-1:0] run_r;
  logic [TW-1:0] tick_r;
  logic [CW-1:0] n_r, idx_r, rem_r;
  logic [IW-1:0] next_r;
  logic [TW-1:0] delay_r;
  logic [rrts_pkg::TIDX_W-1:0] tidx_r;
  logic        valid_r, sw_r;
  logic [1:0]  qstate_r;
  logic        out_valid_r;
  logic [rrts_pkg::TIDX_W-1:0] out_cur_r;
  logic [TW-1:0] out_now_r;
  logic [1:0]  out_qs_r;
  logic        out_iv_r, out_sw_r;

  logic [CW-1:0] n_eff, idx_inc;
  logic [IW-1:0] rd_idx, walk_idx;
  logic [1:0]    st_rd;
  logic [TW-1:0] wk_rd;
  logic          out_free;

  // effective task count: zero acts as one, clamp at the table size
  always_comb begin
    if (cfg_tasks == '0) begin
      n_eff = CW'(1);
    end else if (32'(cfg_tasks) > 32'(rrts_pkg::MAX_TASKS)) begin
      n_eff = CW'(rrts_pkg::MAX_TASKS);
    end else begin
      n_eff = CW'(cfg_tasks);
    end
  end

  assign walk_idx = idx_r[IW-1:0];
  assign idx_inc  = idx_r + CW'(1);

  always_comb begin
    case (ctl.op)
      rrts_pkg::OP_TICK_CHK, rrts_pkg::OP_SRCH: rd_idx = walk_idx;
      rrts_pkg::OP_UNBLK, rrts_pkg::OP_QUERY:   rd_idx = IW'(tidx_r);
      default:                                  rd_idx = run_r;
    endcase
  end

  assign st_rd    = state_r[rd_idx];
  assign wk_rd    = wake_r[walk_idx];
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    case (ctl.op)
      rrts_pkg::OP_TICK_CHK: stat.busy = (idx_r != n_r - CW'(1));
      rrts_pkg::OP_MODN:     stat.busy = (idx_r >= n_r);
      rrts_pkg::OP_SRCH:     stat.busy = (st_rd != rrts_pkg::ST_READY) && (rem_r != CW'(1));
      rrts_pkg::OP_OUT:      stat.busy = !out_free;
      default:               stat.busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rrts_pkg::MAX_TASKS; i++) begin
        state_r[i] <= rrts_pkg::ST_READY;
      end
      run_r       <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result loads the register, else a taken result empties it
      if (ctl.op == rrts_pkg::OP_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (ctl.disp && in_tvalid) begin
        delay_r  <= in_sleep_ticks;
        tidx_r   <= in_task_sel;
        n_r      <= n_eff;
        valid_r  <= (32'(in_task_sel) < 32'(n_eff));
        qstate_r <= rrts_pkg::ST_READY;
        sw_r     <= 1'b0;
      end
      case (ctl.op)
        rrts_pkg::OP_TICK_INC: begin
          tick_r <= tick_r + TW'(1);
          idx_r  <= '0;
        end
        rrts_pkg::OP_TICK_CHK: begin
          if (st_rd == rrts_pkg::ST_SLEEPING && tick_r >= wk_rd) begin
            state_r[walk_idx] <= rrts_pkg::ST_READY;
          end
          idx_r <= idx_inc;
        end
        rrts_pkg::OP_DEMOTE: begin
          if (st_rd == rrts_pkg::ST_RUNNING) begin
            state_r[run_r] <= rrts_pkg::ST_READY;
          end
          idx_r <= CW'(run_r) + CW'(1);
          rem_r <= n_r;
        end
        rrts_pkg::OP_MODN: begin
          if (idx_r >= n_r) begin
            idx_r <= idx_r - n_r;
          end
        end
        rrts_pkg::OP_SRCH: begin
          if (st_rd == rrts_pkg::ST_READY) begin
            next_r <= walk_idx;
          end else if (rem_r == CW'(1)) begin
            next_r <= run_r;  // nothing ready: keep the current task
          end else begin
            idx_r <= (idx_inc == n_r) ? '0 : idx_inc;
            rem_r <= rem_r - CW'(1);
          end
        end
        rrts_pkg::OP_COMMIT: begin
          run_r           <= next_r;
          state_r[next_r] <= rrts_pkg::ST_RUNNING;
        end
        rrts_pkg::OP_SLEEP: begin
          state_r[run_r] <= rrts_pkg::ST_SLEEPING;
          wake_r[run_r]  <= tick_r + delay_r;
          sw_r           <= 1'b1;
        end
        rrts_pkg::OP_BLOCK: begin
          state_r[run_r] <= rrts_pkg::ST_BLOCKED;
          sw_r           <= 1'b1;
        end
        rrts_pkg::OP_UNBLK: begin
          if (valid_r && st_rd == rrts_pkg::ST_BLOCKED) begin
            state_r[rd_idx] <= rrts_pkg::ST_READY;
          end
        end
        rrts_pkg::OP_QUERY: begin
          qstate_r <= valid_r ? st_rd : rrts_pkg::ST_READY;
        end
        rrts_pkg::OP_OUT: begin
          if (out_free) begin
            out_cur_r   <= rrts_pkg::TIDX_W'(run_r);
            out_now_r   <= tick_r;
            out_qs_r    <= qstate_r;
            out_iv_r    <= valid_r;
            out_sw_r    <= sw_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid         = out_valid_r;
  assign out_active_task    = out_cur_r;
  assign out_now_ticks      = out_now_r;
  assign out_queried_state  = out_qs_r;
  assign out_index_valid    = out_iv_r;
  assign out_switch_request = out_sw_r;

endmodule

// ----- design/round_robin_task_scheduler.sv -----
// Round-robin task scheduler with sleep timers. Each input item carries one
// operation (tick, schedule, sleep, block, unblock, query) and yields exactly
// one result item with the current task, the tick count, the queried state,
// an index-valid flag and a switch request. A microcoded sequencer steps a
// small datapath that walks the task table one entry per cycle, so the cost
// of an item is set by that walk. Tick walks the N table entries and schedule
// runs the remainder fixup plus the round-robin search, where N is the
// effective task count (1..8). A current task left beyond a lowered count
// needs further fixup, by repeated subtraction of N. One item is in flight
// at a time; the result register lets the next item be taken while a result
// still waits downstream. tasks_in_use is written over the APB-style port
// (byte address 0); the user must write it only while the block is idle, and
// the block itself does not enforce this.
// Depends on rrts_pkg, rrts_seq, rrts_datapath and the macros header.
`timescale 1ns / 1ps
`include "round_robin_task_scheduler_macros.svh"

module round_robin_task_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] sleep_ticks, [34:32] task_sel, rest zero
  input  logic [2:0]  in_tuser,   // [2:0] func
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [2:0] active_task, [34:3] now_ticks,
                                  // [36:35] queried_state, [37] index_valid,
                                  // [38] switch_request, [39] zero
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic REG_TASKS = 1'b0;  // register select on paddr[2]

  rrts_pkg::ctl_t  ctl;
  rrts_pkg::stat_t stat;

  logic [rrts_pkg::CFG_W-1:0]  tasks_r;
  logic [rrts_pkg::TIDX_W-1:0] cur_task;
  logic [rrts_pkg::TICK_W-1:0] now_ticks;
  logic [1:0]                  q_state;
  logic                        idx_valid, sw_req;
  logic                        cfg_wr;

  // APB: zero wait states, write lands on the access cycle
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_TASKS) ? {28'd0, tasks_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tasks_r <= rrts_pkg::CFG_W'(1);
    end else if (cfg_wr && cfg_paddr[2] == REG_TASKS) begin
      tasks_r <= cfg_pwdata[rrts_pkg::CFG_W-1:0];
    end
  end

  rrts_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser),
    .stat      (stat),
    .ctl       (ctl),
    .in_tready (in_tready)
  );

  rrts_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .stat               (stat),
    .cfg_tasks          (tasks_r),
    .in_tvalid          (in_tvalid),
    .in_sleep_ticks     (in_tdata[31:0]),
    .in_task_sel        (in_tdata[34:32]),
    .out_tready         (out_tready),
    .out_tvalid         (out_tvalid),
    .out_active_task    (cur_task),
    .out_now_ticks      (now_ticks),
    .out_queried_state  (q_state),
    .out_index_valid    (idx_valid),
    .out_switch_request (sw_req)
  );

  assign out_tdata = {1'b0, sw_req, idx_valid, q_state, now_ticks, cur_task};

  // the sequencer leaves dispatch once an item is taken
  `RRTS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // a switch request only comes from sleep or block, never with a query state
  `RRTS_ASSERT_IMP(a_switch_no_query, clk, rst_n, out_tvalid && out_tdata[38],
                   out_tdata[36:35] == rrts_pkg::ST_READY)

endmodule

// ----- sim/rrts_checker.sv -----
// Result checker for the round-robin task scheduler: watches the item channels and the
// config port, predicts every result item and compares it. Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_checker #(
  parameter logic [2:0] TASKS_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] sleep_ticks, [34:32] task_sel
  input  logic [2:0]  in_tuser,   // [2:0] func
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [2:0] active_task, [34:3] now_ticks,
                                  // [36:35] queried_state, [37] index_valid,
                                  // [38] switch_request
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          errors,
  output int          backlog
);
  import rrts_pkg::*;

  typedef struct packed {
    logic [2:0]  cur_task;
    logic [31:0] ticks;
    logic [1:0]  qstate;
    logic        idx_ok;
    logic        switch_req;
  } sched_result_t;

  // shadow of the scheduler
  logic [1:0]  task_st [MAX_TASKS];
  logic [31:0] wake_at [MAX_TASKS];
  logic [2:0]  cur_task;
  logic [31:0] tick_now;
  logic [3:0]  tasks_reg;

  sched_result_t due_q[$];
  int fail_cnt = 0;
  int due_cnt  = 0;

  assign errors  = fail_cnt;
  assign backlog = due_cnt;

  function automatic void note_fail(string what);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t ns checker: %s", $time, what);
  endfunction

  // carries out one operation on the shadow state and returns its result item
  function automatic sched_result_t run_op(logic [2:0] fn, logic [31:0] dly,
                                           logic [2:0] tix);
    sched_result_t r;
    int n;
    int idx;
    logic [2:0] pick;
    logic ok;
    n = (tasks_reg == 4'd0) ? 1 : (tasks_reg > MAX_TASKS) ? MAX_TASKS : int'(tasks_reg);
    ok = (int'(tix) < n);
    r = '0;
    case (fn)
      FN_TICK: begin
        tick_now = tick_now + 32'd1;
        for (int i = 0; i < n; i++)
          if (task_st[i] == ST_SLEEPING && tick_now >= wake_at[i]) task_st[i] = ST_READY;
      end
      FN_SCHEDULE: begin
        if (task_st[cur_task] == ST_RUNNING) task_st[cur_task] = ST_READY;
        pick = cur_task;
        // search wraps around and ends on the current task's slot modulo n
        for (int i = 1; i <= n; i++) begin
          idx = (int'(cur_task) + i) % n;
          if (task_st[idx] == ST_READY) begin
            pick = idx[2:0];
            break;
          end
        end
        cur_task = pick;
        task_st[cur_task] = ST_RUNNING;
      end
      FN_SLEEP: begin
        task_st[cur_task] = ST_SLEEPING;
        wake_at[cur_task] = tick_now + dly;
        r.switch_req = 1'b1;
      end
      FN_BLOCK: begin
        task_st[cur_task] = ST_BLOCKED;
        r.switch_req = 1'b1;
      end
      FN_UNBLOCK: begin
        if (ok && task_st[tix] == ST_BLOCKED) task_st[tix] = ST_READY;
      end
      FN_QUERY: begin
        r.qstate = ok ? task_st[tix] : ST_READY;
      end
      default: ;
    endcase
    r.cur_task = cur_task;
    r.ticks    = tick_now;
    r.idx_ok   = ok;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    sched_result_t seen;
    sched_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        task_st[i] = ST_READY;
        wake_at[i] = '0;
      end
      cur_task  = '0;
      tick_now  = '0;
      tasks_reg = 4'd1;
      due_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen = '{cur_task: out_tdata[2:0], ticks: out_tdata[34:3],
                 qstate: out_tdata[36:35], idx_ok: out_tdata[37],
                 switch_req: out_tdata[38]};
        if (due_q.size() == 0) begin
          note_fail("result item with nothing expected");
        end else begin
          want = due_q.pop_front();
          if (seen !== want)
            note_fail($sformatf({"result mismatch: task %0d/%0d ticks %0d/%0d ",
                                 "state %0d/%0d valid %0b/%0b switch %0b/%0b (exp/got)"},
                                want.cur_task, seen.cur_task, want.ticks, seen.ticks,
                                want.qstate, seen.qstate, want.idx_ok, seen.idx_ok,
                                want.switch_req, seen.switch_req));
        end
      end
      if (in_tvalid && in_tready)
        due_q.push_back(run_op(in_tuser, in_tdata[31:0], in_tdata[34:32]));
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == TASKS_ADDR) begin
        if (cfg_pwrite)
          tasks_reg = cfg_pwdata[3:0];
        else if (cfg_prdata !== {28'd0, tasks_reg})
          note_fail($sformatf("tasks_in_use readback: exp %0d got %0d",
                              tasks_reg, cfg_prdata));
      end
    end
    due_cnt = due_q.size();
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the round-robin task scheduler: clock, reset, item and config
// stimulus, sink back-pressure, verdict. Depends on rrts_pkg, rrts_checker and the DUT.
`timescale 1ns / 1ps

module tb;
  import rrts_pkg::*;

  localparam logic [2:0] TASKS_ADDR   = 3'd0;  // tasks_in_use register
  localparam logic [2:0] FN_SPARE_LO  = 3'd6;  // unused operation codes
  localparam logic [2:0] FN_SPARE_HI  = 3'd7;
  localparam int         HOLD_CYCLES  = 300;   // long sink hold-off
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         PHASE_ITEMS  = 85;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [31:0] sleep_ticks, [34:32] task_sel, rest zero
  logic [2:0]  in_tuser;   // [2:0] func
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [2:0] active_task, [34:3] now_ticks,
                           // [36:35] queried_state, [37] index_valid,
                           // [38] switch_request, [39] zero
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int errors;
  int backlog;

  // shared between the source and the sink
  bit calm     = 1'b0;  // no random idling on either side
  bit hold_req = 1'b0;  // ask the sink for one long hold-off

  always #10 clk = ~clk;

  round_robin_task_scheduler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  rrts_checker #(.TASKS_ADDR(TASKS_ADDR)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .errors     (errors),
    .backlog    (backlog)
  );

  // Offers one item and returns at the edge where it is taken. tvalid stays up
  // afterwards so back-to-back items never drop it within one time step; an idle
  // gap, when drawn, lowers it before the next item.
  task automatic offer_op(input logic [2:0] fn, input logic [31:0] dly,
                          input logic [2:0] tix);
    if (!calm && $urandom_range(0, 99) < 13) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {5'd0, tix, dly};
    do @(posedge clk); while (!in_tready);
  endtask

  // Random operation mix. Sleep delays are mostly short so sleepers come back;
  // near-all-ones delays wrap past the counter and wake on the next tick; a few
  // full-range delays park a task for good (wake time beyond any reachable count).
  task automatic offer_random_op();
    int pick;
    logic [2:0] fn;
    logic [31:0] dly;
    pick = $urandom_range(0, 99);
    if (pick < 30)      fn = FN_TICK;
    else if (pick < 55) fn = FN_SCHEDULE;
    else if (pick < 65) fn = FN_SLEEP;
    else if (pick < 73) fn = FN_BLOCK;
    else if (pick < 85) fn = FN_UNBLOCK;
    else if (pick < 96) fn = FN_QUERY;
    else                fn = pick[0] ? FN_SPARE_HI : FN_SPARE_LO;
    pick = $urandom_range(0, 99);
    if (pick < 80)      dly = $urandom_range(0, 12);
    else if (pick < 92) dly = 32'hFFFF_FFFF - $urandom_range(0, 8);
    else if (pick < 97) dly = $urandom_range(13, 400);
    else                dly = $urandom();
    offer_op(fn, dly, 3'($urandom_range(0, 7)));
  endtask

  // Stop offering and wait until every expected result item is out. The first
  // edge lets the checker record an item taken at the current edge.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
  endtask

  // Write tasks_in_use, then read it back; only called with the block idle.
  task automatic set_task_count(input logic [3:0] cnt);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= TASKS_ADDR;
    cfg_pwdata  <= {28'($urandom()), cnt};  // upper bits must be ignored
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Result sink: random stalls, none while calm; on request one long hold-off,
  // counted here, so the block backs up and stalls its input.
  initial begin : result_sink
    int k;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        hold_req = 1'b0;
      end
      out_tready <= calm || ($urandom_range(0, 99) >= 13);
    end
  end

  // Hang guard.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : source
    logic [3:0] counts [10];
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    // zero acts as one, counts above eight act as eight
    counts = '{4'd8, 4'd3, 4'd0, 4'd15, 4'd1, 4'd5, 4'd8, 4'd2, 4'd9, 4'd7};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset task count of one: query in and out of range, then schedule
    // with nothing ready (blocked, then sleeping current task forced to running).
    offer_op(FN_QUERY,    32'd0, 3'd0);
    offer_op(FN_QUERY,    32'd0, 3'd1);
    offer_op(FN_BLOCK,    32'd0, 3'd0);
    offer_op(FN_SCHEDULE, 32'd0, 3'd0);
    offer_op(FN_SLEEP,    32'd2, 3'd0);
    offer_op(FN_SCHEDULE, 32'd0, 3'd0);
    drain();

    // Directed, four tasks: round-robin hand-off, sleep/wake on tick, block and
    // unblock, out-of-range unblock and query, sleep delay wrapping the counter,
    // unused operation codes with all-ones fields.
    set_task_count(4'd4);
    offer_op(FN_SCHEDULE, 32'd0, 3'd0);
    offer_op(FN_SLEEP,    32'd3, 3'd0);
    offer_op(FN_SCHEDULE, 32'd0, 3'd0);
    offer_op(FN_BLOCK,    32'd0, 3'd0);
    offer_op(FN_SCHEDULE, 32'd0, 3'd0);
    offer_op(FN_UNBLOCK,  32'd0, 3'd2);
    offer_op(FN_UNBLOCK,  32'hFFFF_FFFF, 3'd7);
    offer_op(FN_QUERY,    32'd0, 3'd7);
    offer_op(FN_QUERY,    32'd0, 3'd1);
    offer_op(FN_QUERY,    32'd0, 3'd2);
    offer_op(FN_TICK,     32'd0, 3'd0);
    offer_op(FN_TICK,     32'd0, 3'd0);
    offer_op(FN_TICK,     32'd0, 3'd0);
    offer_op(FN_SLEEP,    32'hFFFF_FFFF, 3'd0);
    offer_op(FN_TICK,     32'd0, 3'd0);
    offer_op(FN_SPARE_LO, 32'hFFFF_FFFF, 3'd7);
    offer_op(FN_SPARE_HI, 32'hFFFF_FFFF, 3'd7);
    offer_op(FN_QUERY,    32'd0, 3'd3);
    drain();

    // Random phases, one task count each; lowering the count leaves the current
    // task outside the scheduled range, which the next operations must handle.
    foreach (counts[p]) begin
      set_task_count(counts[p]);
      calm = (p == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ((p == 3 || p == 7) && i == 20) hold_req = 1'b1;  // sink backs up
        if (p == 5 && i == 40) drain();                      // source pauses
        offer_random_op();
      end
      drain();
    end

    calm = 1'b0;
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/rrts_pkg.sv
design/rrts_seq.sv
design/rrts_datapath.sv
design/round_robin_task_scheduler.sv
sim/rrts_checker.sv
sim/tb.sv
